// File: rtl/lifestep_pkg.sv
// ----------------------------------------------------------------------------
// lifestep_pkg
// Types and constants shared by the life automaton step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lifestep_pkg;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESHOLD_W    = 17;
    localparam int DRAW_W         = 16;
    localparam int COLUMN_W       = 10;
    localparam int ROW_W          = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 17;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd1024;
    localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = 17'd0;

    // smallest frame edge the rule is applied to
    localparam int MIN_EDGE = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MUTATE_THR   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              cell_in;
        logic [DRAW_W-1:0] random_draw;
    } in_word_t;

    typedef struct packed {
        logic                next_cell;
        logic                was_mutated;
        logic [COLUMN_W-1:0] cell_column;
        logic [ROW_W-1:0]    cell_row;
        logic                frame_last;
    } out_word_t;

    function automatic logic [1:0] ones3(input logic [2:0] v);
        ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/life_automaton_step_with_mutation.sv
// ----------------------------------------------------------------------------
// life_automaton_step_with_mutation
// Streaming B3/S23 next-generation step with random mutation.
// ----------------------------------------------------------------------------
// Cells enter one word per clock in raster order and the block sustains one
// word per cycle while out_stall is low. Each word reads its column of a 2-bit
// line memory (rows r-1 and r-2) in the accept cycle and is registered in the
// window stage; when that stage fires, the 3x3 window is complete, the rule and
// the mutation compare are evaluated, the column is written back and the result
// lands in the output register. Border cells give no result; frame_last marks
// the last interior cell. The line memory needs no clearing pass: entries are
// written by the first row of every frame before any result reads them.
`default_nettype none

module life_automaton_step_with_mutation #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      cfg_write,
    input  wire  [lifestep_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [lifestep_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                      in_valid,
    output logic                                     in_stall,
    input  lifestep_pkg::in_word_t                   in_data,
    output logic                                     out_valid,
    input  wire                                      out_stall,
    output lifestep_pkg::out_word_t                  out_data
);

    localparam int CB   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RB   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCMP = (CB + 1 > lifestep_pkg::FRAME_WIDTH_W) ?
                          CB + 1 : lifestep_pkg::FRAME_WIDTH_W;
    localparam int HCMP = (RB + 1 > lifestep_pkg::FRAME_HEIGHT_W) ?
                          RB + 1 : lifestep_pkg::FRAME_HEIGHT_W;

    // configuration
    logic [lifestep_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [lifestep_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [lifestep_pkg::THRESHOLD_W-1:0]    threshold_reg;

    // position of the next word
    logic [CB-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;

    // window stage
    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_cell_reg;
    logic [lifestep_pkg::DRAW_W-1:0]   s1_draw_reg;
    logic [CB-1:0]                     s1_col_reg;
    logic [RB-1:0]                     s1_row_reg;
    logic                              s1_last_reg;
    logic [5:0]                        window_reg, window_next;
    logic [1:0]                        rd_reg;

    // output register
    logic                              out_valid_reg, out_valid_next;
    lifestep_pkg::out_word_t           out_word_reg, out_word_next;

    // line memory: bit0 = row r-1, bit1 = row r-2
    logic [1:0] line_mem [MAX_WIDTH];

    logic [WCMP-1:0] w_eff, fw_ext, col_plus;
    logic [HCMP-1:0] h_eff, fh_ext, row_plus;
    logic            col_wrap, row_wrap;
    logic            accept, out_free, s1_fire, s1_interior;
    logic [2:0]      new_col, left_col, mid_col;
    logic [3:0]      count;
    logic            cur, rule_next, mutate;
    logic [CB-1:0]   col_m1;
    logic [RB-1:0]   row_m1;

    // effective frame size, clamped to the legal range
    always_comb
    begin
        fw_ext = WCMP'(frame_width_reg);
        fh_ext = HCMP'(frame_height_reg);
        if (fw_ext < WCMP'(lifestep_pkg::MIN_EDGE))
            w_eff = WCMP'(lifestep_pkg::MIN_EDGE);
        else if (fw_ext > WCMP'(MAX_WIDTH))
            w_eff = WCMP'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        if (fh_ext < HCMP'(lifestep_pkg::MIN_EDGE))
            h_eff = HCMP'(lifestep_pkg::MIN_EDGE);
        else if (fh_ext > HCMP'(MAX_HEIGHT))
            h_eff = HCMP'(MAX_HEIGHT);
        else
            h_eff = fh_ext;
    end

    assign col_plus = WCMP'(col_reg) + WCMP'(1);
    assign row_plus = HCMP'(row_reg) + HCMP'(1);
    assign col_wrap = (col_plus >= w_eff);
    assign row_wrap = (row_plus >= h_eff);

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // window evaluation
    always_comb
    begin
        new_col     = {rd_reg[1], rd_reg[0], s1_cell_reg};
        left_col    = window_reg[5:3];
        mid_col     = window_reg[2:0];
        cur         = mid_col[1];
        count       = 4'(lifestep_pkg::ones3(left_col)) + 4'(lifestep_pkg::ones3(mid_col))
                    + 4'(lifestep_pkg::ones3(new_col)) - 4'(cur);
        rule_next   = (count == 4'd3) || (cur && (count == 4'd2));
        mutate      = ({1'b0, s1_draw_reg} < threshold_reg);
        s1_interior = (s1_col_reg >= CB'(2)) && (s1_row_reg >= RB'(2));
        col_m1      = s1_col_reg - CB'(1);
        row_m1      = s1_row_reg - RB'(1);
        window_next = s1_fire ? {mid_col, new_col} : window_reg;
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : RB'(row_plus);
            end
            else
            begin
                col_next = CB'(col_plus);
            end
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        // drop the taken word, then load a new one if the window produces it
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (s1_fire && s1_interior)
        begin
            out_valid_next            = 1'b1;
            out_word_next.next_cell   = mutate ? !cur : rule_next;
            out_word_next.was_mutated = mutate;
            out_word_next.cell_column = lifestep_pkg::COLUMN_W'(col_m1);
            out_word_next.cell_row    = lifestep_pkg::ROW_W'(row_m1);
            out_word_next.frame_last  = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lifestep_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= lifestep_pkg::FRAME_HEIGHT_RESET;
            threshold_reg    <= lifestep_pkg::THRESHOLD_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            window_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (lifestep_pkg::cfg_index_t'(cfg_index))
                    lifestep_pkg::CFG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[lifestep_pkg::FRAME_WIDTH_W-1:0];
                    lifestep_pkg::CFG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[lifestep_pkg::FRAME_HEIGHT_W-1:0];
                    lifestep_pkg::CFG_MUTATE_THR:
                        threshold_reg <= cfg_data[lifestep_pkg::THRESHOLD_W-1:0];
                    default:
                        ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= in_data.cell_in;
            s1_draw_reg <= in_data.random_draw;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= col_wrap && row_wrap;
        end
        out_word_reg <= out_word_next;
    end

    // line memory: read on accept, write back the shifted column when the
    // window advances; back-to-back words always touch different columns
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= line_mem[col_reg];
        if (s1_fire)
            line_mem[s1_col_reg] <= {rd_reg[0], s1_cell_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

`default_nettype wire

// File: tb/life_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_step_checker
// Passive checker for the life automaton step block. It follows the config
// port, runs its own B3/S23 next-generation predictor with mutation on every
// accepted input word, and compares each accepted result word, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module life_step_checker (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [lifestep_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [lifestep_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                                  in_valid,
    input  wire                                  in_stall,
    input  lifestep_pkg::in_word_t               in_data,
    input  wire                                  out_valid,
    input  wire                                  out_stall,
    input  lifestep_pkg::out_word_t              out_data,
    output int                                   fail_count,
    output int                                   pending
);

    localparam int LINE_DEPTH   = 1024;
    localparam int MAX_ROWS     = 4096;
    localparam int REPORT_LIMIT = 100;

    logic [lifestep_pkg::FRAME_WIDTH_W-1:0]  width_reg;
    logic [lifestep_pkg::FRAME_HEIGHT_W-1:0] height_reg;
    logic [lifestep_pkg::THRESHOLD_W-1:0]    threshold_reg;

    // rows r-1 and r-2, by column
    bit                      row_above  [LINE_DEPTH];
    bit                      row_above2 [LINE_DEPTH];
    // columns c-1 (low) and c-2 (high); bit0 = row r, bit2 = row r-2
    logic [5:0]              window;
    int unsigned             col_pos;
    int unsigned             row_pos;
    lifestep_pkg::out_word_t expected_cells[$];
    int                      errors = 0;

    function automatic int unsigned clamp_edge(input int unsigned v, input int unsigned hi);
        if (v < lifestep_pkg::MIN_EDGE)
            return lifestep_pkg::MIN_EDGE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predictor by one cell and queue the result it completes.
    function automatic void predict_next_cell(input lifestep_pkg::in_word_t w);
        int unsigned             fw;
        int unsigned             fh;
        int unsigned             idx;
        int unsigned             neighbours;
        int unsigned             col_m1;
        int unsigned             row_m1;
        logic [2:0]              fresh;
        logic [2:0]              left;
        logic [2:0]              mid;
        logic                    cur;
        lifestep_pkg::out_word_t res;

        fw = clamp_edge(width_reg, LINE_DEPTH);
        fh = clamp_edge(height_reg, MAX_ROWS);
        idx = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
        fresh = {row_above2[idx], row_above[idx], w.cell_in};
        left = window[5:3];
        mid = window[2:0];

        if (col_pos >= 2 && row_pos >= 2)
        begin
            cur = mid[1];
            neighbours = $countones(left) + $countones(mid) + $countones(fresh) - cur;
            res.next_cell = (neighbours == 3) || (cur && neighbours == 2);
            res.was_mutated = {1'b0, w.random_draw} < threshold_reg;
            if (res.was_mutated)
                res.next_cell = ~cur;
            col_m1 = col_pos - 1;
            row_m1 = row_pos - 1;
            res.cell_column = col_m1[lifestep_pkg::COLUMN_W-1:0];
            res.cell_row = row_m1[lifestep_pkg::ROW_W-1:0];
            res.frame_last = (col_pos + 1 >= fw) && (row_pos + 1 >= fh);
            expected_cells.push_back(res);
        end

        row_above2[idx] = row_above[idx];
        row_above[idx] = w.cell_in;
        window = {mid, fresh};

        // a counter past a shrunken edge wraps here as well
        if (col_pos + 1 >= fw)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= fh) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lifestep_pkg::out_word_t want;

        if (!rst_n)
        begin
            width_reg = lifestep_pkg::FRAME_WIDTH_RESET;
            height_reg = lifestep_pkg::FRAME_HEIGHT_RESET;
            threshold_reg = lifestep_pkg::THRESHOLD_RESET;
            window = '0;
            col_pos = 0;
            row_pos = 0;
            expected_cells.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_cells.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t ns: result word %h with nothing expected, expected none",
                                 $time, out_data);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    compare_field("next_cell", want.next_cell, out_data.next_cell);
                    compare_field("was_mutated", want.was_mutated, out_data.was_mutated);
                    compare_field("cell_column", want.cell_column, out_data.cell_column);
                    compare_field("cell_row", want.cell_row, out_data.cell_row);
                    compare_field("frame_last", want.frame_last, out_data.frame_last);
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    lifestep_pkg::CFG_FRAME_WIDTH:
                        width_reg = cfg_data[lifestep_pkg::FRAME_WIDTH_W-1:0];
                    lifestep_pkg::CFG_FRAME_HEIGHT:
                        height_reg = cfg_data[lifestep_pkg::FRAME_HEIGHT_W-1:0];
                    lifestep_pkg::CFG_MUTATE_THR:
                        threshold_reg = cfg_data[lifestep_pkg::THRESHOLD_W-1:0];
                    default:
                        ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_next_cell(in_data);
        end

        fail_count <= errors;
        pending <= expected_cells.size();
    end

endmodule

// File: tb/life_automaton_step_with_mutation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_step_with_mutation_test
// Streams frames of cells through the life step block: a few small directed
// frames on the clamp and mutation edges, one 48-wide frame that fills every
// column a random width can reach, then random segments with config changes
// in between, under random source gaps and sink stalls. The checker does the
// comparing.
// ----------------------------------------------------------------------------
module life_automaton_step_with_mutation_test;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 1080;
    localparam int WIDE_EDGE     = 48;
    // index that decodes to no register
    localparam logic [lifestep_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    // raster order, bit 0 = row 0 column 0; rows of three
    localparam logic [14:0] FIRST_FRAME = 15'b111_111_001_010_011;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_write;
    logic [lifestep_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lifestep_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    lifestep_pkg::in_word_t               in_data;
    logic                                 out_valid;
    logic                                 out_stall;
    lifestep_pkg::out_word_t              out_data;
    int                                   fail_count;
    int                                   pending;
    int                                   send_pace;
    int                                   stall_pace;

    life_automaton_step_with_mutation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    life_step_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // pace 0: never pause; 1: light; 2: heavy, with a few long pauses
    function automatic int pick_pause(input int pace);
        int roll;

        if (pace == 0)
            return 0;
        roll = $urandom_range(99);
        if (roll < ((pace == 1) ? 75 : 40))
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [lifestep_pkg::DRAW_W-1:0] random_draw();
        logic [31:0] r;

        r = $urandom;
        return r[lifestep_pkg::DRAW_W-1:0];
    endfunction

    task automatic send_cell(input logic alive, input logic [lifestep_pkg::DRAW_W-1:0] draw);
        int gap;

        gap = pick_pause(send_pace);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {alive, draw};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid, wait for every predicted word, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lifestep_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lifestep_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // sink side: runs of ready cycles broken by stalls
    initial
    begin
        int run;

        out_stall <= 1'b0;
        forever
        begin
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            run = pick_pause(stall_pace);
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int                                   i;
        int                                   k;
        int                                   sent;
        int                                   seg_words;
        int                                   density;
        int                                   roll;
        logic                                 write_it;
        logic [31:0]                          bits;
        logic [lifestep_pkg::CFG_INDEX_W-1:0] idx;
        logic [lifestep_pkg::CFG_DATA_W-1:0]  value;
        logic [lifestep_pkg::DRAW_W-1:0]      draw;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= lifestep_pkg::CFG_FRAME_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        send_pace = 1;
        stall_pace = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x5 frame from a zero width; draws just below, at and far above a threshold of one
        write_reg(lifestep_pkg::CFG_FRAME_WIDTH, '0);
        write_reg(lifestep_pkg::CFG_FRAME_HEIGHT, 17'd5);
        write_reg(lifestep_pkg::CFG_MUTATE_THR, 17'd1);
        for (i = 0; i < 15; i++)
        begin
            case (i)
                8:       draw = '0;
                11:      draw = 16'd1;
                14:      draw = '1;
                default: draw = random_draw();
            endcase
            send_cell(FIRST_FRAME[i], draw);
        end
        settle();

        // all alive, top draw against a full-scale threshold still flips
        write_reg(lifestep_pkg::CFG_FRAME_WIDTH, 17'd3);
        write_reg(lifestep_pkg::CFG_FRAME_HEIGHT, '0);
        write_reg(lifestep_pkg::CFG_MUTATE_THR, 17'd65536);
        for (i = 0; i < 9; i++)
            send_cell(1'b1, (i == 8) ? 16'hFFFF : random_draw());
        settle();

        // widest random frame; leaves every line store column it can reach written
        write_reg(lifestep_pkg::CFG_FRAME_WIDTH, 17'(WIDE_EDGE));
        write_reg(lifestep_pkg::CFG_FRAME_HEIGHT, 17'd3);
        write_reg(lifestep_pkg::CFG_MUTATE_THR, 17'd6000);
        for (i = 0; i < WIDE_EDGE * 3; i++)
            send_cell($urandom_range(99) < 40, random_draw());
        settle();

        // random segments; config may change mid-frame
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            for (k = 0; k < 4; k++)
            begin
                roll = $urandom_range(99);
                write_it = (k < 3) ? (roll < 60) : (roll < 5);
                roll = $urandom_range(99);
                bits = $urandom;
                case (k)
                    0:
                    begin
                        idx = lifestep_pkg::CFG_FRAME_WIDTH;
                        if (roll < 75)
                            value = $urandom_range(3, 12);
                        else if (roll < 85)
                            value = $urandom_range(0, 2);
                        else
                            value = $urandom_range(13, WIDE_EDGE);
                        if (bits[31])
                            value[lifestep_pkg::CFG_DATA_W-1:lifestep_pkg::FRAME_WIDTH_W] =
                                bits[lifestep_pkg::CFG_DATA_W-lifestep_pkg::FRAME_WIDTH_W-1:0];
                    end
                    1:
                    begin
                        idx = lifestep_pkg::CFG_FRAME_HEIGHT;
                        if (roll < 75)
                            value = $urandom_range(3, 10);
                        else if (roll < 85)
                            value = $urandom_range(0, 2);
                        else if (roll < 93)
                            value = $urandom_range(11, 40);
                        else if (roll < 97)
                            value = 17'd4096;
                        else
                            value = $urandom_range(4097, 8191);
                        if (bits[31])
                            value[lifestep_pkg::CFG_DATA_W-1:lifestep_pkg::FRAME_HEIGHT_W] =
                                bits[lifestep_pkg::CFG_DATA_W-lifestep_pkg::FRAME_HEIGHT_W-1:0];
                    end
                    2:
                    begin
                        idx = lifestep_pkg::CFG_MUTATE_THR;
                        if (roll < 35)
                            value = '0;
                        else if (roll < 60)
                            value = $urandom_range(0, 65535);
                        else if (roll < 75)
                            value = $urandom_range(0, 2048);
                        else if (roll < 85)
                            value = 17'd65536;
                        else if (roll < 90)
                            value = 17'd65535;
                        else if (roll < 95)
                            value = $urandom_range(65537, 131071);
                        else
                            value = 17'd131071;
                    end
                    default:
                    begin
                        idx = CFG_SPARE;
                        value = bits[lifestep_pkg::CFG_DATA_W-1:0];
                    end
                endcase
                if (write_it)
                    write_reg(idx, value);
            end

            roll = $urandom_range(9);
            send_pace = (roll < 2) ? 0 : (roll < 7) ? 1 : 2;
            roll = $urandom_range(9);
            stall_pace = (roll < 2) ? 0 : (roll < 7) ? 1 : 2;
            density = $urandom_range(15, 85);
            seg_words = $urandom_range(10, 120);
            for (i = 0; i < seg_words; i++)
                send_cell($urandom_range(99) < density, random_draw());
            sent += seg_words;
            settle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lifestep_pkg.sv
rtl/life_automaton_step_with_mutation.sv
tb/life_step_checker.sv
tb/life_automaton_step_with_mutation_test.sv
